[rtl/core/cmm_pkg.sv]
// Shared types and constants of the color matrix min/max block.
package cmm_pkg;

    localparam int CHANNELS    = 3;
    localparam int SAMPLE_IN_W = 16;
    localparam int RES_W       = 36;
    localparam int CFG_W       = 54;
    localparam int CFG_ADDR_W  = 2;
    localparam int IN_DATA_W   = CHANNELS * SAMPLE_IN_W;
    localparam int OUT_DATA_W  = 2 * CHANNELS * RES_W;

    // Queue depth must be a power of two; the front keeps its two stages in flight
    // against this depth.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_ADDR_W-1:0] REG_ROW_ZERO = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_ONE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_TWO  = 2'd2;

    typedef struct packed {
        logic                              frame_start;
        logic                              frame_end;
        logic [CHANNELS-1:0][RES_W-1:0]    value;
    } cmm_item_t;

endpackage

[rtl/core/cmm_front.sv]
// Front end: coefficient registers, matrix products and channel sums.
module cmm_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cmm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [cmm_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cmm_pkg::IN_DATA_W-1:0]     in_data,
    input  logic                              in_start,
    input  logic                              in_end,
    input  logic [cmm_pkg::QCNT_W-1:0]        q_count,
    output logic                              push,
    output cmm_pkg::cmm_item_t                push_item
);
    import cmm_pkg::*;

    localparam int ROW_W  = CHANNELS * COEF_WIDTH;
    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1 << (COEF_WIDTH - 4));

    logic [CHANNELS-1:0][ROW_W-1:0] row_reg;

    logic                     v1_reg;
    logic                     start1_reg;
    logic                     end1_reg;
    logic signed [PROD_W-1:0] prod_reg  [CHANNELS][CHANNELS];
    logic signed [PROD_W-1:0] prod_next [CHANNELS][CHANNELS];

    logic                     v2_reg;
    logic                     start2_reg;
    logic                     end2_reg;
    logic signed [RES_W-1:0]  sum_reg  [CHANNELS];
    logic signed [RES_W-1:0]  sum_next [CHANNELS];

    logic [QCNT_W+1:0]        in_flight;
    logic                     accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                row_reg[c] <= ROW_W'(COEF_ONE) << (c * COEF_WIDTH);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ROW_ZERO: row_reg[0] <= cfg_data[ROW_W-1:0];
                REG_ROW_ONE:  row_reg[1] <= cfg_data[ROW_W-1:0];
                REG_ROW_TWO:  row_reg[2] <= cfg_data[ROW_W-1:0];
                default:      ;
            endcase
        end
    end

    // Accept only while the queue can hold every item already in the pipe.
    assign in_flight = (QCNT_W+2)'(q_count) + (QCNT_W+2)'(v1_reg) + (QCNT_W+2)'(v2_reg);
    assign in_ready  = in_flight < (QCNT_W+2)'(QUEUE_DEPTH);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                prod_next[c][i] =
                    PROD_W'($signed({1'b0, in_data[i*SAMPLE_IN_W +: SAMPLE_WIDTH]})) *
                    PROD_W'($signed(row_reg[c][i*COEF_WIDTH +: COEF_WIDTH]));
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum_next[c] = RES_W'(SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1]) +
                                 SUM_W'(prod_reg[c][2]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        start1_reg <= in_start;
        end1_reg   <= in_end;
        prod_reg   <= prod_next;
        start2_reg <= start1_reg;
        end2_reg   <= end1_reg;
        sum_reg    <= sum_next;
    end

    assign push = v2_reg;

    always_comb
    begin
        push_item.frame_start = start2_reg;
        push_item.frame_end   = end2_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            push_item.value[c] = sum_reg[c];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_flight <= (QCNT_W+2)'(QUEUE_DEPTH))
        else $error("front pipe holds more items than the queue can take");

endmodule

[rtl/core/cmm_queue.sv]
// Short queue between the arithmetic front end and the tracker back end.
module cmm_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  cmm_pkg::cmm_item_t            push_item,
    input  logic                          pop,
    output logic                          head_valid,
    output cmm_pkg::cmm_item_t            head_item,
    output logic [cmm_pkg::QCNT_W-1:0]    count
);
    import cmm_pkg::*;

    cmm_item_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QCNT_W-1:0]    count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

    assign head_valid = count_reg != '0;
    assign head_item  = mem[rd_ptr_reg];
    assign count      = count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != QCNT_W'(QUEUE_DEPTH)) || pop)
        else $error("push into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from an empty queue");

endmodule

[rtl/core/cmm_back.sv]
// Back end: per-channel running minimum and maximum and the result register.
module cmm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  cmm_pkg::cmm_item_t                head_item,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cmm_pkg::OUT_DATA_W-1:0]    out_data
);
    import cmm_pkg::*;

    logic signed [RES_W-1:0] min_reg  [CHANNELS];
    logic signed [RES_W-1:0] max_reg  [CHANNELS];
    logic signed [RES_W-1:0] min_next [CHANNELS];
    logic signed [RES_W-1:0] max_next [CHANNELS];
    logic signed [RES_W-1:0] value    [CHANNELS];

    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic [OUT_DATA_W-1:0]   out_data_next;

    // A frame-end item needs the result register free, or leaving this cycle.
    assign pop = head_valid && (!head_item.frame_end || !out_valid_reg || out_ready);

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            value[c] = $signed(head_item.value[c]);
            if (head_item.frame_start || value[c] < min_reg[c])
            begin
                min_next[c] = value[c];
            end
            else
            begin
                min_next[c] = min_reg[c];
            end
            if (head_item.frame_start || value[c] > max_reg[c])
            begin
                max_next[c] = value[c];
            end
            else
            begin
                max_next[c] = max_reg[c];
            end
            out_data_next[c*RES_W +: RES_W]            = min_next[c];
            out_data_next[(CHANNELS+c)*RES_W +: RES_W] = max_next[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            if (head_item.frame_end)
            begin
                out_data_reg <= out_data_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && head_item.frame_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_item.frame_end |=> out_valid_reg)
        else $error("frame end taken without a result");

endmodule

[rtl/core/color_matrix_minmax_reduce_core.sv]
// Top level of the color matrix block with per-frame min/max tracking.
//
// Usage: pixels enter on the s_axis channel, one per transfer. tuser marks the
// first pixel of a frame, which loads the trackers; tlast marks the last pixel.
// Each pixel is multiplied by the 3x3 matrix of signed Q4.14 coefficients held in
// three row registers, written through cfg_we/cfg_addr/cfg_data while idle.
// After the last pixel of a frame one transfer on m_axis carries the minimum
// and maximum of each output channel over the frame.
// Throughput is one pixel per cycle while the queue has room: a two-stage
// multiply and sum front end feeds a four-entry queue, and the back end folds
// one queued item per cycle unless a frame end waits for a busy result register.
// When m_axis_tready is low the result holds in its register, the back end
// folds pixels until it meets the next frame end, and then the queue fills and
// s_axis_tready drops once queue and front pipe together hold four items.
// Reset clears the pipe and queue and loads the identity matrix; the trackers
// hold no meaningful value until a frame-start pixel is taken.
module color_matrix_minmax_reduce_core #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cmm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [cmm_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sample_zero, sample_one, sample_two
    input  logic [cmm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // frame_start
    input  logic [0:0]                        s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // min_zero, min_one, min_two, max_zero, max_one, max_two
    output logic [cmm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import cmm_pkg::*;

    logic                push;
    cmm_item_t           push_item;
    logic                pop;
    logic                head_valid;
    cmm_item_t           head_item;
    logic [QCNT_W-1:0]   q_count;

    cmm_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_start  (s_axis_tuser[0]),
        .in_end    (s_axis_tlast),
        .q_count   (q_count),
        .push      (push),
        .push_item (push_item)
    );

    cmm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .count      (q_count)
    );

    cmm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule
